FILE: rtl/fde_pkg.sv
// Package with command codes and shared types of the framebuffer draw engine.
`timescale 1ns / 1ps
package fde_pkg;
	localparam int CoordW = 12;
	localparam int ColorW = 32;

	typedef enum logic [2:0] {
		CMD_PIXEL = 3'd0,
		CMD_LINE  = 3'd1,
		CMD_TRI   = 3'd2,
		CMD_RECT  = 3'd3,
		CMD_GRID  = 3'd4,
		CMD_CLEAR = 3'd5,
		CMD_READ  = 3'd6,
		CMD_NONE  = 3'd7
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [11:0] x_a;
		logic signed [11:0] y_a;
		logic signed [11:0] x_b;
		logic signed [11:0] y_b;
		logic signed [11:0] x_c;
		logic signed [11:0] y_c;
		logic [11:0]        rect_width;
		logic [11:0]        rect_height;
		logic [11:0]        grid_spacing;
		logic [31:0]        color;
	} item_t;
endpackage

FILE: rtl/framebuffer_draw_engine.sv
// Top level of the framebuffer draw engine.
`timescale 1ns / 1ps
// The engine takes one drawing command per s_axis transaction into a two-entry queue and
// carries it out in a back-end sequencer that writes at most one pixel per cycle into a
// FB_WIDTH x FB_HEIGHT frame store. The command code travels in s_axis_tuser. A rectangle
// covers its clipped area, a grid or clear sweeps the whole store, a line gets its
// increments from two 28-bit bit-serial divisions, and a triangle is drawn as three lines.
// A read answer is registered: the sequencer passes from ST_RWAIT to ST_RDATA, where the
// answer is valid on m_axis and held until it is taken; m_axis_tuser says whether the pixel
// lay inside the store. The frame store powers up undefined; read only pixels that have
// been drawn.
module framebuffer_draw_engine import fde_pkg::*; #(
	parameter int FB_WIDTH  = 128,
	parameter int FB_HEIGHT = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// x_a, y_a, x_b, y_b, x_c, y_c, rect_width, rect_height, grid_spacing, color
	input  logic [143:0] s_axis_tdata,
	// cmd
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_color
	output logic [31:0]  m_axis_tdata,
	// read_inside
	output logic         m_axis_tuser
);
	item_t in_item, q_item;
	logic  q_valid, q_ready;
	logic [31:0] res_color;
	logic res_inside;

	assign in_item.cmd          = cmd_t'(s_axis_tuser);
	assign in_item.x_a          = s_axis_tdata[11:0];
	assign in_item.y_a          = s_axis_tdata[23:12];
	assign in_item.x_b          = s_axis_tdata[35:24];
	assign in_item.y_b          = s_axis_tdata[47:36];
	assign in_item.x_c          = s_axis_tdata[59:48];
	assign in_item.y_c          = s_axis_tdata[71:60];
	assign in_item.rect_width   = s_axis_tdata[83:72];
	assign in_item.rect_height  = s_axis_tdata[95:84];
	assign in_item.grid_spacing = s_axis_tdata[107:96];
	assign in_item.color        = s_axis_tdata[139:108];

	fde_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	fde_back #(.FbWidth(FB_WIDTH), .FbHeight(FB_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_color(res_color), .res_inside(res_inside)
	);

	assign m_axis_tdata = res_color;
	assign m_axis_tuser = res_inside;
endmodule

FILE: rtl/fde_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module fde_ram #(
	parameter int Width = 32,
	parameter int Depth = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/fde_front.sv
// Front end: accepts commands, drops ignored ones and queues the rest.
`timescale 1ns / 1ps
module fde_front import fde_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  q_valid,
	input  logic  q_ready,
	output item_t q_item
);
	localparam int Depth = 2;

	item_t      buf_q [Depth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push, pop;

	// Code 7 and a grid of spacing zero leave no trace, so they never enter the queue.
	assign keep = !(in_item.cmd == CMD_NONE ||
	                (in_item.cmd == CMD_GRID && in_item.grid_spacing == '0));
	assign in_ready = (cnt_q != 2'(Depth));
	assign push = in_valid && in_ready && keep;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: rtl/fde_div.sv
// Restoring divider: unsigned 28-bit dividend by 12-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module fde_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [27:0] dividend,
	input  logic [11:0] divisor,
	output logic        busy,
	output logic [27:0] quotient
);
	logic [4:0]  cnt_q;
	logic [27:0] quo_q;
	logic [12:0] rem_q;
	logic [11:0] dsr_q;
	logic [12:0] trial;
	logic [12:0] diff;

	assign trial = {rem_q[11:0], quo_q[27]};
	assign diff = trial - {1'b0, dsr_q};
	assign busy = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd28;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			if (!diff[12]) begin
				rem_q <= diff;
				quo_q <= {quo_q[26:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[26:0], 1'b0};
			end
		end
	end
endmodule

FILE: rtl/fde_back.sv
// Back end: sequencer that draws pixels, lines, triangles, rectangles, grids and clears, and serves reads.
`timescale 1ns / 1ps
module fde_back import fde_pkg::*; #(
	parameter int FbWidth  = 128,
	parameter int FbHeight = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] res_color,
	output logic        res_inside
);
	localparam int Depth = FbWidth * FbHeight;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int XW    = (FbWidth > 1) ? $clog2(FbWidth) : 1;
	localparam int YW    = (FbHeight > 1) ? $clog2(FbHeight) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LSETUP, ST_DIVX, ST_DIVY, ST_LSTEP, ST_AREA, ST_RWAIT, ST_RDATA
	} state_t;

	state_t             state_q;
	item_t              it_q;
	logic [1:0]         edge_q;
	logic signed [12:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [12:0] dx_q, dy_q;
	logic [11:0]        n_q, k_q;
	logic signed [29:0] px_q, py_q, ix_q, iy_q;
	// Area sweep: current position and bounds
	logic signed [13:0] ax_q, ay_q, axl_q, axh_q, ayh_q;
	logic [11:0]        gx_q, gy_q;
	logic               rd_in_q;
	logic               div_go_q;

	logic               div_start, div_busy;
	logic [27:0]        div_num, div_quo;
	logic               we;
	logic [AddrW-1:0]   waddr, raddr;
	logic [31:0]        rdata;
	logic               wr_ok;
	logic signed [13:0] wx, wy;
	logic signed [12:0] adx, ady;
	logic signed [13:0] sx, sy;
	// Rectangle bounds of the queued command, already clipped to the store
	logic signed [13:0] rxl, rxh, ryl, ryh;
	logic               rect_empty;

	fde_ram #(.Width(32), .Depth(Depth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(it_q.color),
		.raddr(raddr), .rdata(rdata)
	);
	fde_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(n_q), .busy(div_busy), .quotient(div_quo)
	);

	assign adx = dx_q[12] ? -dx_q : dx_q;
	assign ady = dy_q[12] ? -dy_q : dy_q;

	// Truncation toward zero of Q.16 position
	function automatic logic signed [13:0] trunc16(input logic signed [29:0] p);
		logic signed [13:0] f;
		f = p[29:16];
		if (p[29] && p[15:0] != '0)
			f = f + 14'sd1;
		return f;
	endfunction

	always_comb begin
		sx = trunc16(px_q);
		sy = trunc16(py_q);
		if (state_q == ST_LSTEP) begin
			wx = sx;
			wy = sy;
		end else begin
			wx = ax_q;
			wy = ay_q;
		end
		wr_ok = (wx >= 0) && (wx < 14'(FbWidth)) && (wy >= 0) && (wy < 14'(FbHeight));
		waddr = AddrW'(wy) * AddrW'(FbWidth) + AddrW'(wx);
		we = 1'b0;
		// The last step position is the end point, which is never drawn.
		if (state_q == ST_LSTEP)
			we = wr_ok && (k_q != n_q);
		else if (state_q == ST_AREA)
			we = wr_ok && (it_q.cmd != CMD_GRID || gx_q == '0 || gy_q == '0);
		raddr = AddrW'(it_q.y_a) * AddrW'(FbWidth) + AddrW'(it_q.x_a);
		div_num = (state_q == ST_DIVX) ? {adx[11:0], 16'b0} : {ady[11:0], 16'b0};
		div_start = div_go_q && (n_q != '0) &&
		            (state_q == ST_DIVX || state_q == ST_DIVY);

		rxl = 14'(q_item.x_a) - 14'({1'b0, q_item.rect_width[11:1]});
		rxh = rxl + 14'(q_item.rect_width);
		ryl = 14'(q_item.y_a) - 14'({1'b0, q_item.rect_height[11:1]});
		ryh = ryl + 14'(q_item.rect_height);
		if (rxl < 0)
			rxl = '0;
		if (ryl < 0)
			ryl = '0;
		if (rxh > 14'(FbWidth))
			rxh = 14'(FbWidth);
		if (ryh > 14'(FbHeight))
			ryh = 14'(FbHeight);
		rect_empty = (rxl >= rxh) || (ryl >= ryh);
	end

	assign q_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RDATA);
	assign res_color = rd_in_q ? rdata : '0;
	assign res_inside = rd_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						it_q   <= q_item;
						edge_q <= '0;
						x0_q   <= 13'(q_item.x_a);
						y0_q   <= 13'(q_item.y_a);
						x1_q   <= 13'(q_item.x_b);
						y1_q   <= 13'(q_item.y_b);
						dx_q   <= 13'(q_item.x_b) - 13'(q_item.x_a);
						dy_q   <= 13'(q_item.y_b) - 13'(q_item.y_a);
						case (q_item.cmd)
							CMD_LINE, CMD_TRI: state_q <= ST_LSETUP;
							CMD_PIXEL: begin
								ax_q <= 14'(q_item.x_a); ay_q <= 14'(q_item.y_a);
								axl_q <= 14'(q_item.x_a); axh_q <= 14'(q_item.x_a) + 14'sd1;
								ayh_q <= 14'(q_item.y_a) + 14'sd1;
								state_q <= ST_AREA;
							end
							CMD_RECT: begin
								if (rect_empty) begin
									state_q <= ST_IDLE;
								end else begin
									ax_q  <= rxl;
									axl_q <= rxl;
									ay_q  <= ryl;
									axh_q <= rxh;
									ayh_q <= ryh;
									state_q <= ST_AREA;
								end
							end
							CMD_GRID, CMD_CLEAR: begin
								ax_q <= '0; ay_q <= '0; axl_q <= '0;
								axh_q <= 14'(FbWidth); ayh_q <= 14'(FbHeight);
								gx_q <= '0; gy_q <= '0;
								state_q <= ST_AREA;
							end
							CMD_READ: begin
								rd_in_q <= (q_item.x_a >= 0) && (14'(q_item.x_a) < 14'(FbWidth))
								           && (q_item.y_a >= 0) && (14'(q_item.y_a) < 14'(FbHeight));
								state_q <= ST_RWAIT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LSETUP: begin
					n_q  <= (adx >= ady) ? adx[11:0] : ady[11:0];
					px_q <= 30'(x0_q) <<< 16;
					py_q <= 30'(y0_q) <<< 16;
					k_q  <= '0;
					state_q  <= ST_DIVX;
					div_go_q <= 1'b1;
				end
				ST_DIVX: begin
					if (n_q == '0) begin
						state_q <= ST_LSTEP;
					end else if (!div_busy && !div_go_q) begin
						ix_q <= dx_q[12] ? -30'(div_quo) : 30'(div_quo);
						state_q  <= ST_DIVY;
						div_go_q <= 1'b1;
					end
				end
				ST_DIVY: begin
					if (!div_busy && !div_go_q) begin
						iy_q <= dy_q[12] ? -30'(div_quo) : 30'(div_quo);
						state_q <= ST_LSTEP;
					end
				end
				ST_LSTEP: begin
					if (k_q == n_q) begin
						if (it_q.cmd == CMD_TRI && edge_q != 2'd2) begin
							edge_q <= edge_q + 2'd1;
							x0_q <= x1_q; y0_q <= y1_q;
							if (edge_q == 2'd0) begin
								x1_q <= 13'(it_q.x_c); y1_q <= 13'(it_q.y_c);
								dx_q <= 13'(it_q.x_c) - x1_q; dy_q <= 13'(it_q.y_c) - y1_q;
							end else begin
								x1_q <= 13'(it_q.x_a); y1_q <= 13'(it_q.y_a);
								dx_q <= 13'(it_q.x_a) - x1_q; dy_q <= 13'(it_q.y_a) - y1_q;
							end
							state_q <= ST_LSETUP;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						px_q <= px_q + ix_q;
						py_q <= py_q + iy_q;
						k_q  <= k_q + 12'd1;
					end
				end
				ST_AREA: begin
					if (ax_q + 14'sd1 >= axh_q) begin
						ax_q <= axl_q;
						gx_q <= '0;
						ay_q <= ay_q + 14'sd1;
						gy_q <= (gy_q + 12'd1 == it_q.grid_spacing) ? '0 : gy_q + 12'd1;
						if (ay_q + 14'sd1 >= ayh_q)
							state_q <= ST_IDLE;
					end else begin
						ax_q <= ax_q + 14'sd1;
						gx_q <= (gx_q + 12'd1 == it_q.grid_spacing) ? '0 : gx_q + 12'd1;
					end
				end
				ST_RWAIT: state_q <= ST_RDATA;
				ST_RDATA: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/fde_checker.sv
// Port-level assertions for the framebuffer draw engine, bound to the top level.
`timescale 1ns / 1ps
module fde_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [143:0] s_axis_tdata,
	input logic [2:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [31:0]  m_axis_tdata,
	input logic         m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("outside read gave a colour");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("command changed while waiting");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tuser))
		else $error("result flag unknown");
endmodule

bind framebuffer_draw_engine fde_checker u_fde_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
	.s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
